// ----- rtl/cfm_pkg.sv -----
`timescale 1ns / 1ps
// Package for the capture frequency meter: field widths, register indexes,
// input command codes and overflow counter limits. No dependencies.
package cfm_pkg;

    // Fixed widths of the stream fields and configuration registers.
    localparam int COUNTER_BITS  = 16;
    localparam int CLOCK_HZ_W    = 28;
    localparam int RELOAD_W      = 16;
    localparam int FREQ_W        = 36;
    localparam int CFG_DATA_W    = 28;
    localparam int CFG_ADDR_W    = 1;
    localparam int S_TDATA_W     = 16;
    localparam int M_TDATA_W     = 40;

    // Default number of fraction bits of the frequency word.
    localparam int FRACTION_BITS_DEF = 8;

    localparam logic [FREQ_W-1:0] FREQ_MAX = {FREQ_W{1'b1}};

    // Reset values of the configuration registers.
    localparam logic [CLOCK_HZ_W-1:0] CLOCK_HZ_RESET = CLOCK_HZ_W'(1000000);
    localparam logic [RELOAD_W-1:0]   RELOAD_RESET   = RELOAD_W'(65535);

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_TIMER_CLOCK_HZ = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_AUTO_RELOAD    = 1'b1;

    // Input word kinds, carried on s_tuser.
    localparam logic CMD_EDGE     = 1'b0;
    localparam logic CMD_OVERFLOW = 1'b1;

    // Overflow counter: saturation value and the count that marks inactivity.
    localparam logic [1:0] OVF_SAT      = 2'd3;
    localparam logic [1:0] OVF_INACTIVE = 2'd2;

endpackage

// ----- rtl/capture_frequency_meter.sv -----
`timescale 1ns / 1ps
// Capture frequency meter. An overflow word, a first edge or a zero period goes
// from acceptance through ST_DONE to the output register; an edge that needs a
// division first passes through ST_DIV, where the bit-serial divider works it out.
// One word is in work at a time: the input takes no new word until the result has
// been handed to the output register. Reset (synchronous, active low)
// restores the register defaults and the no-edge-seen state.
module capture_frequency_meter #(
    parameter int FRACTION_BITS = cfm_pkg::FRACTION_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input stream.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [cfm_pkg::S_TDATA_W-1:0]   s_tdata,   // [15:0] capture_value
    input  logic [0:0]                      s_tuser,   // [0] cmd
    // Result stream.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [cfm_pkg::M_TDATA_W-1:0]   m_tdata,   // [35:0] frequency_q8, [39:36] zero
    output logic [0:0]                      m_tuser,   // [0] signal_inactive
    // Configuration write port.
    input  logic                            cfg_wr_en,
    input  logic [cfm_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [cfm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import cfm_pkg::*;

    // The dividend is the timer clock scaled up by the fraction bits.
    localparam int DIVIDEND_W = CLOCK_HZ_W + FRACTION_BITS;
    localparam int CMP_W      = (DIVIDEND_W > FREQ_W) ? DIVIDEND_W : FREQ_W;

    // Sequencer states.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]              state_reg,     state_next;
    logic [CLOCK_HZ_W-1:0]   clock_hz_reg,  clock_hz_next;
    logic [RELOAD_W-1:0]     reload_reg,    reload_next;
    logic [COUNTER_BITS-1:0] last_cap_reg,  last_cap_next;
    logic                    first_pend_reg, first_pend_next;
    logic [1:0]              ovf_cnt_reg,   ovf_cnt_next;
    logic [FREQ_W-1:0]       freq_reg,      freq_next;
    logic                    m_valid_reg,   m_valid_next;
    logic [FREQ_W-1:0]       m_freq_reg,    m_freq_next;
    logic                    m_inact_reg,   m_inact_next;

    logic                    accept;
    logic [COUNTER_BITS-1:0] cap;
    logic [COUNTER_BITS+1:0] wrap_top;
    logic [COUNTER_BITS+1:0] wrap_diff;
    logic [COUNTER_BITS-1:0] period;
    logic                    div_start;
    logic                    div_done;
    logic [DIVIDEND_W-1:0]   div_quot;
    logic [DIVIDEND_W-1:0]   dividend;
    logic [FREQ_W-1:0]       quot_sat;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign cap      = s_tdata[COUNTER_BITS-1:0];

    // Period in timer ticks. When the counter wrapped, the period runs from the
    // previous capture up to the reload value and on from zero to this capture.
    // A period that comes out as zero or negative is reported as zero, which
    // the sequencer turns into a zero frequency without dividing.
    assign wrap_top  = {2'b00, reload_reg} + {2'b00, cap} + (COUNTER_BITS+2)'(1);
    assign wrap_diff = wrap_top - {2'b00, last_cap_reg};

    always_comb begin
        if (cap > last_cap_reg) begin
            period = cap - last_cap_reg;
        end else if (cap < last_cap_reg && wrap_top > {2'b00, last_cap_reg}) begin
            period = wrap_diff[COUNTER_BITS-1:0];
        end else begin
            period = '0;
        end
    end

    assign dividend = DIVIDEND_W'(clock_hz_reg) << FRACTION_BITS;

    // Large quotients only arise when there are more fraction bits than the
    // frequency word has room for; they clamp to the largest frequency.
    always_comb begin
        if (CMP_W'(div_quot) > CMP_W'(FREQ_MAX)) begin
            quot_sat = FREQ_MAX;
        end else begin
            quot_sat = FREQ_W'(CMP_W'(div_quot));
        end
    end

    always_comb begin
        state_next      = state_reg;
        clock_hz_next   = clock_hz_reg;
        reload_next     = reload_reg;
        last_cap_next   = last_cap_reg;
        first_pend_next = first_pend_reg;
        ovf_cnt_next    = ovf_cnt_reg;
        freq_next       = freq_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_freq_next     = m_freq_reg;
        m_inact_next    = m_inact_reg;
        div_start       = 1'b0;

        // Register writes are to arrive only while the block is idle; the block itself does not enforce this.
        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_TIMER_CLOCK_HZ: clock_hz_next = cfg_wdata[CLOCK_HZ_W-1:0];
                REG_AUTO_RELOAD:    reload_next   = cfg_wdata[RELOAD_W-1:0];
                default:            ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_DONE;
                    if (s_tuser[0] == CMD_EDGE) begin
                        // Every edge clears the overflow count and becomes the
                        // reference for the next one. The first edge only
                        // records its capture.
                        ovf_cnt_next    = '0;
                        last_cap_next   = cap;
                        first_pend_next = 1'b0;
                        if (!first_pend_reg) begin
                            if (period != '0) begin
                                div_start  = 1'b1;
                                state_next = ST_DIV;
                            end else begin
                                freq_next = '0;
                            end
                        end
                    end else begin
                        // Overflow count saturates; the second overflow without
                        // an edge declares the signal gone and zeroes the reading.
                        if (ovf_cnt_reg != OVF_SAT) begin
                            ovf_cnt_next = ovf_cnt_reg + 2'd1;
                            if (ovf_cnt_next == OVF_INACTIVE) begin
                                freq_next = '0;
                            end
                        end
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    freq_next  = quot_sat;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // Hand the result to the output register once it is free.
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_freq_next  = freq_reg;
                    m_inact_next = (ovf_cnt_reg >= OVF_INACTIVE);
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    cfm_divider #(
        .DIVIDEND_W (DIVIDEND_W),
        .DIVISOR_W  (COUNTER_BITS)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (period),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            clock_hz_reg   <= CLOCK_HZ_RESET;
            reload_reg     <= RELOAD_RESET;
            last_cap_reg   <= '0;
            first_pend_reg <= 1'b1;
            ovf_cnt_reg    <= '0;
            freq_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clock_hz_reg   <= clock_hz_next;
            reload_reg     <= reload_next;
            last_cap_reg   <= last_cap_next;
            first_pend_reg <= first_pend_next;
            ovf_cnt_reg    <= ovf_cnt_next;
            freq_reg       <= freq_next;
            m_valid_reg    <= m_valid_next;
        end
        m_freq_reg  <= m_freq_next;
        m_inact_reg <= m_inact_next;
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = M_TDATA_W'(m_freq_reg);
    assign m_tuser[0] = m_inact_reg;

endmodule

// ----- rtl/cfm_divider.sv -----
`timescale 1ns / 1ps
// Restoring divider for the capture frequency meter, one quotient bit a cycle.
// Depends on nothing outside itself.
module cfm_divider #(
    parameter int DIVIDEND_W = 36,
    parameter int DIVISOR_W  = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg,    busy_next;
    logic                  done_reg,    done_next;
    logic [CNT_W-1:0]      cnt_reg,     cnt_next;
    logic [DIVIDEND_W-1:0] quo_reg,     quo_next;
    logic [DIVISOR_W-1:0]  rem_reg,     rem_next;
    logic [DIVISOR_W-1:0]  dvs_reg,     dvs_next;

    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W+1:0]  diff;
    logic                  fits;

    // The dividend shifts out of the top of quo_reg while quotient bits enter below.
    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, dvs_reg};
    assign fits  = ~diff[DIVISOR_W+1];

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            rem_next = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DIVIDEND_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- rtl/cfm_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the capture frequency meter, bound to the top level.
// Depends on cfm_pkg for the port widths.
module cfm_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [cfm_pkg::M_TDATA_W-1:0]   m_tdata,
    input logic [0:0]                      m_tuser
);
    import cfm_pkg::*;

    // A stalled result word holds still.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // An inactive signal always reads as zero frequency.
    a_inactive_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[FREQ_W-1:0] == '0)
        else $error("inactive signal with non-zero frequency");

    // Only one word is in work: the input closes right after an acceptance.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready straight after acceptance");

    // Padding above the frequency field stays zero.
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[M_TDATA_W-1:FREQ_W] == '0)
        else $error("non-zero padding in result word");

endmodule

bind capture_frequency_meter cfm_checker u_cfm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- tb/capture_frequency_meter_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for capture_frequency_meter: streams edge and overflow words,
// predicts every result word and compares it field by field as it leaves the block.
// Depends on cfm_pkg and the capture_frequency_meter RTL only.
module capture_frequency_meter_tb;
    import cfm_pkg::*;

    // The block is built with its default number of fraction bits.
    localparam int FRAC = FRACTION_BITS_DEF;
    localparam logic [CLOCK_HZ_W-1:0] CLOCK_HZ_MAX = {CLOCK_HZ_W{1'b1}};
    localparam logic [RELOAD_W-1:0]   RELOAD_MAX   = {RELOAD_W{1'b1}};
    // Generous ceiling on the whole run, in ns.
    localparam longint RUN_LIMIT_NS = 5_000_000;

    // One predicted result word.
    typedef struct packed {
        logic [FREQ_W-1:0] freq_q;
        logic              inactive;
    } meter_result_t;

    // Receiver behaviour; the mode in force is chosen anew at random.
    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_COIN,
        READY_EVERY_EIGHTH,
        READY_RARE
    } ready_mode_t;

    // ------------------------------------------------------------------
    // Scoreboard: a private model of the meter plus the queue of result
    // words that it has predicted but not yet seen.
    // ------------------------------------------------------------------
    class freq_scoreboard;
        logic [CLOCK_HZ_W-1:0]   clock_hz;
        logic [RELOAD_W-1:0]     reload;
        logic [COUNTER_BITS-1:0] last_cap;
        bit                      awaiting_first;
        logic [1:0]              ovf_count;
        logic [FREQ_W-1:0]       freq;
        meter_result_t           expected_q[$];
        int unsigned             errors;

        function new();
            clock_hz       = CLOCK_HZ_RESET;
            reload         = RELOAD_RESET;
            last_cap       = '0;
            awaiting_first = 1'b1;
            ovf_count      = '0;
            freq           = '0;
            errors         = 0;
        endfunction

        function void write_register(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_TIMER_CLOCK_HZ: clock_hz = val[CLOCK_HZ_W-1:0];
                REG_AUTO_RELOAD:    reload   = val[RELOAD_W-1:0];
                default: ;
            endcase
        endfunction

        // Timer clock over the period, in fixed point, saturated to the field.
        function logic [FREQ_W-1:0] rate_for_period(longint unsigned ticks);
            longint unsigned num;
            longint unsigned quot;
            if (ticks == 0)
                return '0;
            num  = clock_hz;
            num  = num << FRAC;
            quot = num / ticks;
            if (quot > FREQ_MAX)
                return FREQ_MAX;
            return quot[FREQ_W-1:0];
        endfunction

        // Called for every accepted input word.
        function void note_word(logic cmd, logic [COUNTER_BITS-1:0] cap);
            longint unsigned prev;
            longint unsigned cur;
            longint unsigned top;
            meter_result_t   res;
            if (cmd == CMD_EDGE) begin
                ovf_count = '0;
                if (awaiting_first) begin
                    // The first edge only primes the previous capture.
                    last_cap       = cap;
                    awaiting_first = 1'b0;
                end else begin
                    prev     = last_cap;
                    cur      = cap;
                    last_cap = cap;
                    if (cur > prev) begin
                        freq = rate_for_period(cur - prev);
                    end else if (cur < prev) begin
                        // The counter wrapped; a capture above the reload value can
                        // leave no positive period, which reads as zero.
                        top  = longint'(reload) + cur + 1;
                        freq = (top > prev) ? rate_for_period(top - prev) : '0;
                    end else begin
                        freq = '0;
                    end
                end
            end else begin
                if (ovf_count < OVF_SAT) begin
                    ovf_count = ovf_count + 2'd1;
                    if (ovf_count == OVF_INACTIVE)
                        freq = '0;
                end
            end
            res.freq_q   = freq;
            res.inactive = (ovf_count >= OVF_INACTIVE);
            expected_q.push_back(res);
        endfunction

        // Called for every accepted result word.
        function void check_result(logic [M_TDATA_W-1:0] tdata, logic [0:0] tuser);
            meter_result_t want;
            if (expected_q.size() == 0) begin
                $error("unexpected result word: frequency_q8 %0d signal_inactive %0d",
                       tdata[FREQ_W-1:0], tuser[0]);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (tdata[FREQ_W-1:0] !== want.freq_q) begin
                $error("frequency_q8 mismatch: expected %0d, actual %0d",
                       want.freq_q, tdata[FREQ_W-1:0]);
                errors++;
            end
            if (tuser[0] !== want.inactive) begin
                $error("signal_inactive mismatch: expected %0d, actual %0d",
                       want.inactive, tuser[0]);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and the signals around the block. Every input starts
    // at a known value so that nothing is X before reset is released.
    // ------------------------------------------------------------------
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_W-1:0]    s_tdata   = '0;   // [15:0] capture_value
    logic [0:0]              s_tuser   = '0;   // [0] cmd
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]    m_tdata;          // [35:0] frequency_q8, [39:36] zero
    logic [0:0]              m_tuser;          // [0] signal_inactive
    logic                    cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0]   cfg_addr  = '0;
    logic [CFG_DATA_W-1:0]   cfg_wdata = '0;

    freq_scoreboard sb = new();

    // Words still to go in the current sender burst.
    int unsigned burst_left = 0;

    always #2 aclk = ~aclk;

    capture_frequency_meter #(
        .FRACTION_BITS(FRAC)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Receiver: m_tready follows a mode that changes now and then, so that
    // the result side sees long clean stretches as well as heavy stalling.
    // ------------------------------------------------------------------
    ready_mode_t ready_mode      = READY_ALWAYS;
    int unsigned ready_mode_left = 0;
    logic [2:0]  ready_phase     = '0;

    always @(posedge aclk) begin
        ready_phase <= ready_phase + 3'd1;
        if (ready_mode_left == 0) begin
            ready_mode      <= ready_mode_t'($urandom_range(0, 3));
            ready_mode_left <= $urandom_range(20, 300);
        end else begin
            ready_mode_left <= ready_mode_left - 1;
        end
        case (ready_mode)
            READY_ALWAYS:       m_tready <= 1'b1;
            READY_COIN:         m_tready <= 1'($urandom_range(0, 1));
            READY_EVERY_EIGHTH: m_tready <= (ready_phase == 3'd0);
            default:            m_tready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    // Result monitor. Values read straight after the edge are those the block
    // saw at the edge, since its own updates land later in the time step.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
    end

    // ------------------------------------------------------------------
    // Sender. Words go out in bursts; between bursts s_tvalid may drop for a
    // random gap. A gap is only opened where it is non-empty, so s_tvalid
    // never gets two assignments in one time step.
    // ------------------------------------------------------------------
    task automatic send_word(input logic cmd, input logic [COUNTER_BITS-1:0] cap);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            // Now and then a long burst, so that some stretches have no idling.
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 8);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= cap;
        do
            @(posedge aclk);
        while (!s_tready);
        sb.note_word(cmd, cap);
        burst_left--;
    endtask

    // Stops the sender and waits until every predicted word has come back,
    // which leaves the block idle and ready for configuration.
    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0)
            @(posedge aclk);
    endtask

    // Writes both registers on consecutive edges; the block must be idle.
    task automatic program_meter(input logic [CLOCK_HZ_W-1:0] clk_hz,
                                 input logic [RELOAD_W-1:0] top);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_TIMER_CLOCK_HZ;
        cfg_wdata <= CFG_DATA_W'(clk_hz);
        @(posedge aclk);
        sb.write_register(REG_TIMER_CLOCK_HZ, CFG_DATA_W'(clk_hz));
        cfg_addr  <= REG_AUTO_RELOAD;
        cfg_wdata <= CFG_DATA_W'(top);
        @(posedge aclk);
        sb.write_register(REG_AUTO_RELOAD, CFG_DATA_W'(top));
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly a plausible capture train under the current reload value, with
    // overflow runs and some captures taken at random anywhere in the range.
    task automatic random_phase(input int unsigned count, input logic [RELOAD_W-1:0] top);
        int unsigned prev;
        int unsigned delta;
        int unsigned n;
        int unsigned runs;
        prev = $urandom_range(0, top);
        n    = 0;
        while (n < count) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    // A run of overflows, sometimes long enough to go inactive.
                    runs = $urandom_range(1, 4);
                    repeat (runs) begin
                        send_word(CMD_OVERFLOW, COUNTER_BITS'($urandom_range(0, 65535)));
                        n++;
                    end
                end
                2: begin
                    prev = $urandom_range(0, 65535);
                    send_word(CMD_EDGE, COUNTER_BITS'(prev));
                    n++;
                end
                default: begin
                    case ($urandom_range(0, 4))
                        0:       delta = 0;
                        1:       delta = $urandom_range(1, 15);
                        2:       delta = $urandom_range(1, 255);
                        default: delta = $urandom_range(1, top);
                    endcase
                    prev = (prev + delta) % (int'(top) + 1);
                    send_word(CMD_EDGE, COUNTER_BITS'(prev));
                    n++;
                end
            endcase
        end
        drain();
    endtask

    // Run limit, kept apart from the stimulus.
    initial begin
        #(RUN_LIMIT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        logic [CLOCK_HZ_W-1:0] clk_hz;
        logic [RELOAD_W-1:0]   top;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part at the reset register values. Overflows before any edge
        // walk the counter to inactivity and then into saturation.
        send_word(CMD_OVERFLOW, 16'h0000);
        send_word(CMD_OVERFLOW, 16'hFFFF);
        send_word(CMD_OVERFLOW, 16'h0000);
        send_word(CMD_OVERFLOW, 16'h0000);
        // First edge primes the capture and leaves the frequency alone.
        send_word(CMD_EDGE, 16'h0000);
        send_word(CMD_EDGE, 16'd100);
        // Equal captures read as zero.
        send_word(CMD_EDGE, 16'd100);
        send_word(CMD_EDGE, 16'hFFFF);
        // Wrap to zero: a one-tick period, the largest frequency.
        send_word(CMD_EDGE, 16'h0000);
        send_word(CMD_EDGE, 16'h0001);
        // A lone overflow is cleared by the next edge; two in a row mark the signal inactive first.
        send_word(CMD_OVERFLOW, 16'h0000);
        send_word(CMD_EDGE, 16'h5555);
        send_word(CMD_OVERFLOW, 16'h0000);
        send_word(CMD_OVERFLOW, 16'h0000);
        send_word(CMD_EDGE, 16'hAAAA);
        drain();

        // Fastest timer with a short reload: a capture above the reload value
        // that leaves no positive wrapped period, then ordinary periods and a wrap.
        program_meter(CLOCK_HZ_MAX, 16'd1000);
        send_word(CMD_EDGE, 16'd5000);
        send_word(CMD_EDGE, 16'd10);
        send_word(CMD_EDGE, 16'd999);
        send_word(CMD_EDGE, 16'd500);
        send_word(CMD_EDGE, 16'd501);
        drain();

        // A timer clock of zero gives zero whatever the period.
        program_meter('0, RELOAD_MAX);
        send_word(CMD_EDGE, 16'd7);
        send_word(CMD_EDGE, 16'd9);
        drain();

        // Slowest timer with the smallest reload.
        program_meter(CLOCK_HZ_W'(1), RELOAD_W'(1));
        send_word(CMD_EDGE, 16'd0);
        send_word(CMD_EDGE, 16'd1);
        send_word(CMD_EDGE, 16'd0);
        drain();

        // Random part: eight phases of about 120 words, each under its own
        // register setting, the extremes among them.
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin
                    clk_hz = CLOCK_HZ_RESET;
                    top    = RELOAD_RESET;
                end
                1: begin
                    clk_hz = CLOCK_HZ_MAX;
                    top    = RELOAD_MAX;
                end
                2: begin
                    clk_hz = CLOCK_HZ_W'(1);
                    top    = RELOAD_W'($urandom_range(1, 65535));
                end
                3: begin
                    clk_hz = CLOCK_HZ_W'($urandom_range(1, 268435455));
                    top    = RELOAD_W'(1);
                end
                4: begin
                    clk_hz = CLOCK_HZ_W'($urandom_range(1, 268435455));
                    top    = RELOAD_W'($urandom_range(1, 255));
                end
                default: begin
                    clk_hz = CLOCK_HZ_W'($urandom_range(1, 268435455));
                    top    = RELOAD_W'($urandom_range(1, 65535));
                end
            endcase
            program_meter(clk_hz, top);
            random_phase(120, top);
        end

        // Everything is back; give the block a short while to show any stray word.
        repeat (60) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
